@@ hdl/dpc_pkg.sv @@
package dpc_pkg;

  localparam int MAX_SUM = 1024;
  localparam int DEPTH   = MAX_SUM + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IN_W    = 11;
  localparam int CNT_W   = 30;
  localparam int CMP_W   = (ADDR_W > IN_W) ? ADDR_W : IN_W;

  localparam logic [CNT_W-1:0] MODULUS = CNT_W'(1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAIN,
    ST_UPDATE,
    ST_READ,
    ST_WAIT
  } dpc_state_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_clear;
    logic              wr_one;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              res_load;
  } dpc_ctrl_t;

endpackage

@@ hdl/distinct_partition_counter_unit.sv @@
// channel   | ports                                        | direction
// ----------+----------------------------------------------+----------
// input     | in_valid, in_stall, in_target_sum, in_max_part | in
// result    | out_valid, out_stall, out_partition_count    | out
//
// One word first clears entries 0..t, then makes one pass for each part k,
// updating entries t down to k through the single table write port.
// The count table needs no reset; each word rewrites entries 0..t first.
// rst_n is synchronous; it drops any word in progress and any pending result.
// A new word is taken while a finished result still waits under out_stall.
module distinct_partition_counter_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [dpc_pkg::IN_W-1:0]  in_target_sum,
  input  logic [dpc_pkg::IN_W-1:0]  in_max_part,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dpc_pkg::CNT_W-1:0] out_partition_count
);
  import dpc_pkg::*;

  logic [CMP_W-1:0]  tgt_ext, part_ext, tgt_sat, part_sat;
  logic [ADDR_W-1:0] tgt, part;
  dpc_ctrl_t         ctrl;
  logic [CNT_W-1:0]  rd_data_a, rd_data_b, sum, wr_data;
  logic [CNT_W-1:0]  count_r;

  // saturate the target to the table size and the part to the target
  assign tgt_ext  = CMP_W'(in_target_sum);
  assign part_ext = CMP_W'(in_max_part);
  assign tgt_sat  = (tgt_ext > CMP_W'(MAX_SUM)) ? CMP_W'(MAX_SUM) : tgt_ext;
  assign part_sat = (part_ext > tgt_sat) ? tgt_sat : part_ext;
  assign tgt      = tgt_sat[ADDR_W-1:0];
  assign part     = part_sat[ADDR_W-1:0];

  dpc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tgt       (tgt),
    .part      (part),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  dpc_mod_add u_add (
    .a   (rd_data_a),
    .b   (rd_data_b),
    .sum (sum)
  );

  assign wr_data = ctrl.wr_clear ? (ctrl.wr_one ? CNT_W'(1) : '0) : sum;

  dpc_table_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CNT_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ctrl.wr_en),
    .wr_addr   (ctrl.wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (ctrl.rd_addr_a),
    .rd_addr_b (ctrl.rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      count_r <= rd_data_a;
    end
  end

  assign out_partition_count = count_r;

endmodule

@@ hdl/dpc_table_ram.sv @@
module dpc_table_ram #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 30
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ hdl/dpc_mod_add.sv @@
module dpc_mod_add (
  input  logic [dpc_pkg::CNT_W-1:0] a,
  input  logic [dpc_pkg::CNT_W-1:0] b,
  output logic [dpc_pkg::CNT_W-1:0] sum
);
  import dpc_pkg::*;

  logic [CNT_W:0] raw;
  logic [CNT_W:0] red;

  assign raw = {1'b0, a} + {1'b0, b};
  assign red = raw - {1'b0, MODULUS};
  // both operands are residues, so one subtract brings the sum back in range
  assign sum = (raw >= {1'b0, MODULUS}) ? red[CNT_W-1:0] : raw[CNT_W-1:0];

endmodule

@@ hdl/dpc_seq.sv @@
module dpc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dpc_pkg::ADDR_W-1:0] tgt,
  input  logic [dpc_pkg::ADDR_W-1:0] part,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dpc_pkg::dpc_ctrl_t         ctrl
);
  import dpc_pkg::*;

  dpc_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] t_r, t_nxt;
  logic [ADDR_W-1:0] m_r, m_nxt;
  logic [ADDR_W-1:0] s_r, s_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic              last_r, last_nxt;
  logic              pend_valid_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    m_nxt     = m_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          t_nxt     = tgt;
          m_nxt     = part;
          s_nxt     = '0;
          k_nxt     = ADDR_W'(1);
          last_nxt  = (part == '0);
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (s_r == t_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          s_nxt = s_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        s_nxt = t_r;
        if (last_r) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (s_r == k_r) begin
          // pass done: let the last write land before the next pass reads
          if (k_r == m_r) begin
            last_nxt = 1'b1;
          end else begin
            k_nxt = k_r + ADDR_W'(1);
          end
          state_nxt = ST_DRAIN;
        end else begin
          s_nxt = s_r - ADDR_W'(1);
        end
      end
      ST_READ: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    ctrl.wr_clear  = (state_r == ST_CLEAR);
    ctrl.wr_one    = (s_r == '0);
    ctrl.wr_en     = (state_r == ST_CLEAR) || pend_valid_r;
    ctrl.wr_addr   = (state_r == ST_CLEAR) ? s_r : pend_addr_r;
    ctrl.rd_addr_a = (state_r == ST_UPDATE) ? s_r : t_r;
    ctrl.rd_addr_b = (state_r == ST_UPDATE) ? (s_r - k_r) : '0;
    ctrl.res_load  = (state_r == ST_WAIT) && out_free;
    out_valid_nxt  = out_valid_r;
    if (ctrl.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= (state_r == ST_UPDATE);
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    m_r         <= m_nxt;
    s_r         <= s_nxt;
    k_r         <= k_nxt;
    last_r      <= last_nxt;
    pend_addr_r <= s_r;
  end

endmodule

@@ tb/sv/tb_distinct_partition_counter_unit.sv @@
`timescale 1ns / 1ps
module tb_distinct_partition_counter_unit;
  import dpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct {
    logic [IN_W-1:0]  target_sum;
    logic [IN_W-1:0]  max_part;
    logic [CNT_W-1:0] partition_count;
  } count_expect_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [IN_W-1:0]  in_target_sum;
  logic [IN_W-1:0]  in_max_part;
  logic             out_valid;
  logic             out_stall;
  logic [CNT_W-1:0] out_partition_count;

  count_expect_t    pending_counts[$];
  count_expect_t    oldest_count;
  logic [CNT_W-1:0] ways [0:MAX_SUM];
  int unsigned      mismatches  = 0;
  int unsigned      cycle_count = 0;
  int unsigned      hold_left   = 0;
  bit               idle_on     = 1'b1;

  distinct_partition_counter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_sum       (in_target_sum),
    .in_max_part         (in_max_part),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_partition_count (out_partition_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count distinct-part partitions of the clamped target, one part size at a time.
  function automatic logic [CNT_W-1:0] count_distinct_partitions(
    input logic [IN_W-1:0] target_sum,
    input logic [IN_W-1:0] max_part
  );
    int              t;
    int              m;
    longint unsigned acc;
    t = (int'(target_sum) > MAX_SUM) ? MAX_SUM : int'(target_sum);
    m = (int'(max_part) > t) ? t : int'(max_part);
    for (int s = 0; s <= t; s++) ways[s] = '0;
    ways[0] = CNT_W'(1);
    for (int k = 1; k <= m; k++) begin
      for (int s = t; s >= k; s--) begin
        acc = longint'(ways[s]) + longint'(ways[s-k]);
        if (acc >= 64'(MODULUS)) acc -= 64'(MODULUS);
        ways[s] = acc[CNT_W-1:0];
      end
    end
    return ways[t];
  endfunction

  task automatic report_mismatch(input string what, input count_expect_t want,
                                 input logic [CNT_W-1:0] got);
    mismatches++;
    $display("[%0t] %s: target %0d max_part %0d got %0d expected %0d",
             $time, what, want.target_sum, want.max_part, got, want.partition_count);
  endtask

  task automatic send_word(input logic [IN_W-1:0] target_sum,
                           input logic [IN_W-1:0] max_part);
    count_expect_t want;
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_target_sum <= target_sum;
    in_max_part   <= max_part;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want.target_sum      = target_sum;
    want.max_part        = max_part;
    want.partition_count = count_distinct_partitions(target_sum, max_part);
    pending_counts.push_back(want);
  endtask

  task automatic test_special_cases();
    send_word(11'd0, 11'd0);
    send_word(11'd0, 11'd2047);
    send_word(11'd1, 11'd0);
    send_word(11'd1, 11'd1);
    send_word(11'd2, 11'd2);
    send_word(11'd3, 11'd2);
    send_word(11'd5, 11'd0);
    send_word(11'd5, 11'd3);
    send_word(11'd5, 11'd5);
    send_word(11'd10, 11'd2047);
    send_word(11'd1, 11'd682);
    send_word(11'd100, 11'd100);
    // targets past the table saturate; keep the part count low to stay short
    send_word(11'd2047, 11'd0);
    send_word(11'd1365, 11'd2);
    send_word(11'd682, 11'd1);
    send_word(11'd1024, 11'd1);
    send_word(11'd1025, 11'd3);
  endtask

  task automatic test_full_size();
    send_word(11'd2047, 11'd1024);
    send_word(11'd1024, 11'd4);
  endtask

  task automatic test_quiet_stretch();
    idle_on = 1'b0;
    repeat (20) send_word(IN_W'($urandom_range(30)), IN_W'($urandom_range(2047)));
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (8) send_word(IN_W'($urandom_range(20)), IN_W'($urandom_range(20)));
  endtask

  task automatic test_random_words();
    logic [IN_W-1:0] target_sum;
    logic [IN_W-1:0] max_part;
    int unsigned     pick;
    repeat (75) begin
      pick = $urandom_range(99);
      if (pick < 70) target_sum = IN_W'($urandom_range(40));
      else if (pick < 85) target_sum = IN_W'($urandom_range(160, 41));
      else target_sum = IN_W'($urandom_range(2047));
      // large targets only with few part sizes, or the run grows quadratically
      if (pick >= 85) max_part = IN_W'($urandom_range(4));
      else if ($urandom_range(1) != 0) max_part = IN_W'($urandom_range(target_sum));
      else max_part = IN_W'($urandom_range(2047));
      send_word(target_sum, max_part);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        oldest_count = '{default: '0};
        report_mismatch("result with no word outstanding", oldest_count,
                        out_partition_count);
      end else begin
        oldest_count = pending_counts.pop_front();
        if (out_partition_count !== oldest_count.partition_count)
          report_mismatch("partition_count mismatch", oldest_count, out_partition_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_target_sum = '0;
    in_max_part   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_full_size();
    test_quiet_stretch();
    test_backpressure();
    test_random_words();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
